[hdl/cvl_pkg.sv]
// shared types and constants of the compacting value list
package cvl_pkg;

    localparam int DEPTH_DEF = 64;
    localparam int VALUE_W   = 32;
    localparam int POS_W     = 6;
    localparam int ECNT_W    = 7;

    // operation codes
    localparam logic [1:0] OP_APPEND = 2'd0;
    localparam logic [1:0] OP_REMOVE = 2'd1;
    localparam logic [1:0] OP_READ   = 2'd2;

    // status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [1:0] ST_BAD_POS   = 2'd2;
    localparam logic [1:0] ST_FULL      = 2'd3;

    typedef struct packed {
        logic [1:0]                op;
        logic signed [VALUE_W-1:0] value;
        logic [POS_W-1:0]          position;
    } in_item_t;

    typedef struct packed {
        logic signed [VALUE_W-1:0] read_value;
        logic [1:0]                status;
        logic [ECNT_W-1:0]         element_count;
    } out_item_t;

    // command broadcast to every cell
    typedef struct packed {
        logic               append;
        logic               remove;
        logic [VALUE_W-1:0] value;
    } cell_cmd_t;

endpackage

[hdl/cvl_stream_if.sv]
// valid/ready stream channel carrying one item
interface cvl_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (
        output valid,
        output payload,
        input  ready
    );

    modport sink (
        input  valid,
        input  payload,
        output ready
    );
endinterface

[hdl/compacting_value_list_core.sv]
// top level of the compacting value list: cell row, count and result register
//
// in_ch takes one item per cycle: op (append, remove first match, read
// position), value and position. out_ch gives one result item for each
// accepted item: read_value, status and element_count after the operation.
// The result sits in an output register the cycle after the item is
// accepted. Throughput is one item per cycle while out_ch takes each result;
// the cycle is set by the row of cells, where every cell compares its entry
// against the value and a found flag ripples along the row so that all cells
// from the first match onwards shift down at the same edge.
// While a result waits, in_ch.ready stays high as long as out_ch.ready is
// high in the same cycle; a stalled receiver holds the result and stops new
// items until it is taken.
// Reset (rst_n low, asynchronous) empties the list and drops any pending
// result; entries themselves are not cleared, only count marks them valid.
// An append to a full list is dropped and reported as full.
module compacting_value_list_core #(
    parameter int DEPTH = cvl_pkg::DEPTH_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    cvl_stream_if.sink   in_ch,
    cvl_stream_if.source out_ch
);
    import cvl_pkg::*;

    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int IDX_W = $clog2(DEPTH);
    localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;
    logic               out_valid_reg;
    logic               out_valid_next;
    out_item_t          out_item_reg;
    out_item_t          out_item_next;

    in_item_t           item;
    logic               in_accept;
    cell_cmd_t          cmd;
    logic [VALUE_W-1:0] cell_data [DEPTH];
    logic [DEPTH-1:0]   found_chain;
    logic               found;
    logic [CMP_W-1:0]   pos_ext;
    logic [CMP_W-1:0]   count_ext;
    logic [IDX_W-1:0]   rd_idx;

    assign item      = in_ch.payload;
    assign in_ch.ready = !out_valid_reg || out_ch.ready;
    assign in_accept = in_ch.valid && in_ch.ready;

    assign cmd.append = in_accept && (item.op == OP_APPEND);
    assign cmd.remove = in_accept && (item.op == OP_REMOVE);
    assign cmd.value  = item.value;

    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++)
        begin : g_cell
            logic [VALUE_W-1:0] right;
            logic               fin;

            if (gi == DEPTH - 1)
            begin : g_last
                assign right = cell_data[gi];
            end
            else
            begin : g_mid
                assign right = cell_data[gi+1];
            end

            if (gi == 0)
            begin : g_first
                assign fin = 1'b0;
            end
            else
            begin : g_next
                assign fin = found_chain[gi-1];
            end

            cvl_cell #(
                .IDX   (gi),
                .CNT_W (CNT_W)
            ) u_cell (
                .clk        (clk),
                .cmd        (cmd),
                .count      (count_reg),
                .right_data (right),
                .found_in   (fin),
                .data       (cell_data[gi]),
                .found_out  (found_chain[gi])
            );
        end
    endgenerate

    assign found     = found_chain[DEPTH-1];
    assign pos_ext   = CMP_W'(item.position);
    assign count_ext = CMP_W'(count_reg);
    assign rd_idx    = pos_ext[IDX_W-1:0];

    always_comb
    begin
        count_next               = count_reg;
        out_item_next.read_value = '0;
        out_item_next.status     = ST_OK;
        case (item.op)
            OP_APPEND:
            begin
                if (count_reg == CNT_W'(DEPTH))
                begin
                    out_item_next.status = ST_FULL;
                end
                else
                begin
                    count_next = count_reg + CNT_W'(1);
                end
            end
            OP_REMOVE:
            begin
                if (found)
                begin
                    count_next = count_reg - CNT_W'(1);
                end
                else
                begin
                    out_item_next.status = ST_NOT_FOUND;
                end
            end
            OP_READ:
            begin
                if (pos_ext < count_ext)
                begin
                    out_item_next.read_value = cell_data[rd_idx];
                end
                else
                begin
                    out_item_next.read_value = '1;
                    out_item_next.status     = ST_BAD_POS;
                end
            end
            default:
            begin
                count_next = count_reg;
            end
        endcase
        out_item_next.element_count = ECNT_W'(count_next);
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (in_accept)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ch.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (in_accept)
            begin
                count_reg <= count_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            out_item_reg <= out_item_next;
        end
    end

    assign out_ch.valid   = out_valid_reg;
    assign out_ch.payload = out_item_reg;

`ifndef SYNTH
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("list count beyond depth");

    a_append_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && item.op == OP_APPEND && count_reg != CNT_W'(DEPTH))
        |=> count_reg == CNT_W'($past(count_reg) + 1'b1))
        else $error("append did not grow the list");

    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> out_valid_reg)
        else $error("accepted item gave no result");

    a_count_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !in_accept |=> $stable(count_reg))
        else $error("count changed without an item");
`endif
endmodule

[hdl/cvl_cell.sv]
// one list cell: holds a single entry, matches and shifts down on remove
module cvl_cell #(
    parameter int IDX   = 0,
    parameter int CNT_W = 7
) (
    input  logic                      clk,
    input  cvl_pkg::cell_cmd_t        cmd,
    input  logic [CNT_W-1:0]          count,
    input  logic [cvl_pkg::VALUE_W-1:0] right_data,
    input  logic                      found_in,
    output logic [cvl_pkg::VALUE_W-1:0] data,
    output logic                      found_out
);
    import cvl_pkg::*;

    logic [VALUE_W-1:0] data_reg;
    logic [VALUE_W-1:0] data_next;
    logic               occupied;
    logic               tail;
    logic               match;

    assign occupied  = count > CNT_W'(IDX);
    assign tail      = count == CNT_W'(IDX);
    assign match     = occupied && (data_reg == cmd.value);
    // set from the first matching cell onwards
    assign found_out = found_in | match;

    always_comb
    begin
        data_next = data_reg;
        if (cmd.append && tail)
        begin
            data_next = cmd.value;
        end
        else if (cmd.remove && found_out)
        begin
            data_next = right_data;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data = data_reg;
endmodule
